// ===== rtl/core/dsrd_pkg.sv =====
// Shared constants and beat types for the sample-record run-length decoder.
package dsrd_pkg;

  // Header size used when the top level is not overridden
  localparam int unsigned HeaderBytesDef = 1024;

  // Header byte offsets
  localparam int unsigned OfsWidth  = 4;
  localparam int unsigned OfsHeight = 5;
  localparam int unsigned OfsTotal  = 6;
  localparam int unsigned OfsMode   = 10 + 4 * 128;

  localparam logic [7:0] StartMarker  = 8'hFF;
  localparam logic [7:0] GrayModeCode = 8'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  pixel_value;
    logic [7:0]  run_length;
    logic [7:0]  start_column;
    logic [7:0]  row_number;
    logic [7:0]  sample_label;
    logic [31:0] sample_number;
    logic        row_end;
    logic        sample_end;
    logic        format_error;
  } out_beat_t;

  // Input register contents as seen by the parser
  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } in_stage_t;

  // Parser result for the current beat
  typedef struct packed {
    logic      emit;
    out_beat_t beat;
  } parse_res_t;

endpackage

// ===== rtl/core/dsrd_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
interface dsrd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/dsrd_in_reg.sv =====
// Input register stage: holds one file byte until the parser takes it.
module dsrd_in_reg
  import dsrd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  dsrd_stream_if.sink        in_i,
  input  logic               take_i,
  output in_stage_t          stage_o
);

  logic     valid_q;
  in_beat_t beat_q;
  logic     accept;

  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q <= in_i.payload;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.beat  = beat_q;

endmodule

// ===== rtl/core/dsrd_parser.sv =====
// Byte parser: header capture, record fields and run decode, one byte per beat.
module dsrd_parser
  import dsrd_pkg::*;
#(
  parameter int unsigned HeaderBytes = HeaderBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_stage_t  stage_i,
  input  logic       take_i,
  output parse_res_t res_o
);

  localparam int unsigned OffsW = $clog2(HeaderBytes);

  typedef enum logic [2:0] {
    PhHeader,
    PhStart,
    PhLabel,
    PhWidth,
    PhHeight,
    PhLen,
    PhData,
    PhDone
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [OffsW-1:0]   ofs_q, ofs_d;
  logic [7:0]         dflt_w_q, dflt_w_d;
  logic [7:0]         dflt_h_q, dflt_h_d;
  logic               gray_q, gray_d;
  logic [31:0]        total_q, total_d;
  logic [31:0]        count_q, count_d;
  logic [7:0]         label_q, label_d;
  logic [7:0]         cur_w_q, cur_w_d;
  logic [7:0]         cur_h_q, cur_h_d;
  logic [7:0]         row_q, row_d;
  logic [7:0]         col_q, col_d;
  logic               black_q, black_d;
  logic [1:0]         fbc_q, fbc_d;
  logic               bad_q, bad_d;

  logic [7:0]  b;
  logic [7:0]  left;
  logic        clip;
  logic [7:0]  run_len;
  logic [8:0]  new_col;
  logic [8:0]  row_inc;
  logic        row_done;
  logic        smp_done;
  logic [31:0] count_inc;
  phase_e      phase_fin;
  logic [1:0]  lane;

  assign b         = stage_i.beat.data_byte;
  // column never reaches the width inside an image, so no wrap here
  assign left      = cur_w_q - col_q;
  assign clip      = !gray_q && (b > left);
  assign run_len   = gray_q ? 8'd1 : (clip ? left : b);
  assign new_col   = {1'b0, col_q} + {1'b0, run_len};
  assign row_inc   = {1'b0, row_q} + 9'd1;
  assign row_done  = new_col >= {1'b0, cur_w_q};
  assign smp_done  = row_done && (row_inc >= {1'b0, cur_h_q});
  assign count_inc = count_q + 32'd1;
  assign phase_fin = (count_inc == total_q) ? PhDone : PhStart;
  assign lane      = 2'(ofs_q - OffsW'(OfsTotal));

  always_comb begin
    phase_d  = phase_q;
    ofs_d    = ofs_q;
    dflt_w_d = dflt_w_q;
    dflt_h_d = dflt_h_q;
    gray_d   = gray_q;
    total_d  = total_q;
    count_d  = count_q;
    label_d  = label_q;
    cur_w_d  = cur_w_q;
    cur_h_d  = cur_h_q;
    row_d    = row_q;
    col_d    = col_q;
    black_d  = black_q;
    fbc_d    = fbc_q;
    bad_d    = bad_q;

    res_o.emit                   = 1'b0;
    res_o.beat.pixel_value       = gray_q ? b : {7'd0, black_q};
    res_o.beat.run_length        = run_len;
    res_o.beat.start_column      = col_q;
    res_o.beat.row_number        = row_q;
    res_o.beat.sample_label      = label_q;
    res_o.beat.sample_number     = count_q;
    res_o.beat.row_end           = row_done;
    res_o.beat.sample_end        = smp_done;
    res_o.beat.format_error      = clip || bad_q;

    if (take_i) begin
      if (stage_i.beat.file_start) begin
        // fresh file: everything cleared, this byte is header offset zero
        phase_d  = PhHeader;
        ofs_d    = OffsW'(1);
        dflt_w_d = '0;
        dflt_h_d = '0;
        gray_d   = 1'b0;
        total_d  = '0;
        count_d  = '0;
        label_d  = '0;
        cur_w_d  = '0;
        cur_h_d  = '0;
        row_d    = '0;
        col_d    = '0;
        black_d  = 1'b0;
        fbc_d    = '0;
        bad_d    = 1'b0;
      end else begin
        unique case (phase_q)
          PhHeader: begin
            if (ofs_q == OffsW'(OfsWidth)) begin
              dflt_w_d = b;
            end else if (ofs_q == OffsW'(OfsHeight)) begin
              dflt_h_d = b;
            end else if (ofs_q >= OffsW'(OfsTotal) && ofs_q < OffsW'(OfsTotal + 4)) begin
              total_d = total_q | (32'(b) << {lane, 3'b000});
            end else if (ofs_q == OffsW'(OfsMode)) begin
              gray_d = (b == GrayModeCode);
            end
            ofs_d = ofs_q + OffsW'(1);
            if (ofs_q == OffsW'(HeaderBytes - 1)) begin
              phase_d = (total_d == '0) ? PhDone : PhStart;
            end
          end
          PhStart: begin
            bad_d   = (b != StartMarker);
            phase_d = PhLabel;
          end
          PhLabel: begin
            label_d = b;
            if (dflt_w_q != '0 && dflt_h_q != '0) begin
              cur_w_d = dflt_w_q;
              cur_h_d = dflt_h_q;
              fbc_d   = '0;
              phase_d = PhLen;
            end else begin
              phase_d = PhWidth;
            end
          end
          PhWidth: begin
            cur_w_d = b;
            phase_d = PhHeight;
          end
          PhHeight: begin
            cur_h_d = b;
            fbc_d   = '0;
            phase_d = PhLen;
          end
          PhLen: begin
            // length bytes are skipped
            fbc_d = fbc_q + 2'd1;
            if (fbc_q != '0) begin
              fbc_d   = '0;
              row_d   = '0;
              col_d   = '0;
              black_d = 1'b0;
              if (cur_w_q == '0 || cur_h_q == '0) begin
                count_d = count_inc;
                phase_d = phase_fin;
              end else begin
                phase_d = PhData;
              end
            end
          end
          PhData: begin
            if (!gray_q && b == '0) begin
              black_d = !black_q;
            end else begin
              res_o.emit = 1'b1;
              if (!gray_q) begin
                black_d = !black_q;
              end
              col_d = new_col[7:0];
              if (row_done) begin
                col_d   = '0;
                black_d = 1'b0;
                row_d   = row_inc[7:0];
                if (smp_done) begin
                  count_d = count_inc;
                  phase_d = phase_fin;
                end
              end
            end
          end
          PhDone: begin
            // trailing bytes dropped until the next file
          end
          default: begin
            phase_d = PhDone;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      ofs_q    <= '0;
      dflt_w_q <= '0;
      dflt_h_q <= '0;
      gray_q   <= 1'b0;
      total_q  <= '0;
      count_q  <= '0;
      label_q  <= '0;
      cur_w_q  <= '0;
      cur_h_q  <= '0;
      row_q    <= '0;
      col_q    <= '0;
      black_q  <= 1'b0;
      fbc_q    <= '0;
      bad_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      ofs_q    <= ofs_d;
      dflt_w_q <= dflt_w_d;
      dflt_h_q <= dflt_h_d;
      gray_q   <= gray_d;
      total_q  <= total_d;
      count_q  <= count_d;
      label_q  <= label_d;
      cur_w_q  <= cur_w_d;
      cur_h_q  <= cur_h_d;
      row_q    <= row_d;
      col_q    <= col_d;
      black_q  <= black_d;
      fbc_q    <= fbc_d;
      bad_q    <= bad_d;
    end
  end

endmodule

// ===== rtl/core/digit_sample_record_rle_decoder.sv =====
// Top level of the sample-record run-length decoder.
// Takes a sample-database file one byte per beat. The first HeaderBytes bytes
// are the header: offset 4 is the default width, 5 the default height, 6..9
// the record total (little-endian) and 522 the mode (1 = gray, else binary).
// Each record then gives a start byte (0xFF expected), a label, width and
// height unless both defaults are nonzero, two skipped length bytes and the
// image. Binary images are run lengths per row, white first, colours
// alternating and restarting white each row; every nonzero run gives one
// result beat, clipped and flagged when it overruns the row. Gray images give
// one result beat per pixel byte. format_error is also set on every result of
// a record whose start byte was wrong. Bytes after the last record are
// dropped; file_start on a byte clears everything and begins a new header.
// Throughput is one byte per clock: the parser decodes each byte combinationally
// between the input register and the output register, so a byte is
// accepted every cycle unless a result is stalled at the output. Output
// backpressure reaches the input ready combinationally through the output
// register's free flag.
module digit_sample_record_rle_decoder
  import dsrd_pkg::*;
#(
  parameter int unsigned HeaderBytes = HeaderBytesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dsrd_stream_if.sink  in_i,
  dsrd_stream_if.source out_o
);

  in_stage_t  stage;
  parse_res_t res;
  logic       take;

  logic      out_valid_q;
  out_beat_t out_beat_q;

  // parser may advance when the result slot is empty or being drained
  assign take = stage.valid && (!out_valid_q || out_o.ready);

  dsrd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .stage_o (stage)
  );

  dsrd_parser #(
    .HeaderBytes (HeaderBytes)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .take_i  (take),
    .res_o   (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= res.emit;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res.emit) begin
      out_beat_q <= res.beat;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_beat_q;

endmodule

// ===== dv/tb.sv =====
// Testbench for the sample-record run-length decoder: byte-stream stimulus and result check.
`timescale 1ns / 1ps

module tb
  import dsrd_pkg::*;
();

  localparam int unsigned HdrBytes       = HeaderBytesDef;
  localparam int unsigned NumRandRecords = 12;

  // Parser phases of the local decoder
  typedef enum logic [2:0] {
    DecHeader,
    DecStart,
    DecLabel,
    DecWidth,
    DecHeight,
    DecLength,
    DecImage,
    DecDone
  } dec_phase_e;

  logic clk_i;
  logic rst_ni;

  dsrd_stream_if #(.T(in_beat_t))  in_ch ();
  dsrd_stream_if #(.T(out_beat_t)) out_ch ();

  digit_sample_record_rle_decoder #(
    .HeaderBytes(HdrBytes)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // File bytes waiting to be driven, and the run results they should give
  in_beat_t    file_bytes[$];
  out_beat_t   expected_runs[$];
  int unsigned beats_total;
  int unsigned beats_taken;
  int unsigned runs_seen;
  int unsigned mismatch_count;

  // ---------------------------------------------------------------------------
  // Local decoder: tracks the header, record and image position of the stream
  // ---------------------------------------------------------------------------
  dec_phase_e  dec_phase;
  int unsigned hdr_pos;
  logic [7:0]  dflt_w, dflt_h;
  bit          gray_img;
  logic [31:0] rec_total, rec_idx;
  logic [7:0]  rec_label, img_w, img_h;
  int          cur_row, cur_col;
  bit          black_next;
  int          len_bytes;
  bit          bad_marker;

  function automatic void clear_decoder();
    dec_phase  = DecHeader;
    hdr_pos    = 0;
    dflt_w     = '0;
    dflt_h     = '0;
    gray_img   = 1'b0;
    rec_total  = '0;
    rec_idx    = '0;
    rec_label  = '0;
    img_w      = '0;
    img_h      = '0;
    cur_row    = 0;
    cur_col    = 0;
    black_next = 1'b0;
    len_bytes  = 0;
    bad_marker = 1'b0;
  endfunction

  // Record complete: either wait for the next start byte or ignore the rest
  function automatic void close_record();
    rec_idx++;
    dec_phase = (rec_idx == rec_total) ? DecDone : DecStart;
  endfunction

  function automatic void emit_run(logic [7:0] value, int len, bit clipped);
    out_beat_t r;
    r.pixel_value   = value;
    r.run_length    = 8'(len);
    r.start_column  = 8'(cur_col);
    r.row_number    = 8'(cur_row);
    r.sample_label  = rec_label;
    r.sample_number = rec_idx;
    r.row_end       = 1'b0;
    r.sample_end    = 1'b0;
    r.format_error  = clipped | bad_marker;
    cur_col += len;
    if (cur_col >= img_w) begin
      r.row_end  = 1'b1;
      cur_col    = 0;
      black_next = 1'b0;
      cur_row++;
      if (cur_row >= img_h) begin
        r.sample_end = 1'b1;
        close_record();
      end
    end
    expected_runs.push_back(r);
  endfunction

  function automatic void decode_byte(in_beat_t beat);
    logic [7:0] b;
    int         run;
    bit         clipped;
    bit         colour;
    b = beat.data_byte;
    if (beat.file_start) clear_decoder();
    case (dec_phase)
      DecHeader: begin
        if (hdr_pos == OfsWidth) dflt_w = b;
        else if (hdr_pos == OfsHeight) dflt_h = b;
        else if (hdr_pos >= OfsTotal && hdr_pos < OfsTotal + 4)
          rec_total |= 32'(b) << (8 * (hdr_pos - OfsTotal));
        else if (hdr_pos == OfsMode) gray_img = (b == GrayModeCode);
        hdr_pos++;
        if (hdr_pos >= HdrBytes) dec_phase = (rec_total == 0) ? DecDone : DecStart;
      end
      DecStart: begin
        bad_marker = (b != StartMarker);
        dec_phase  = DecLabel;
      end
      DecLabel: begin
        rec_label = b;
        // both defaults set: the record carries no size bytes
        if (dflt_w != 0 && dflt_h != 0) begin
          img_w     = dflt_w;
          img_h     = dflt_h;
          len_bytes = 0;
          dec_phase = DecLength;
        end else begin
          dec_phase = DecWidth;
        end
      end
      DecWidth: begin
        img_w     = b;
        dec_phase = DecHeight;
      end
      DecHeight: begin
        img_h     = b;
        len_bytes = 0;
        dec_phase = DecLength;
      end
      DecLength: begin
        len_bytes++;
        if (len_bytes >= 2) begin
          len_bytes  = 0;
          cur_row    = 0;
          cur_col    = 0;
          black_next = 1'b0;
          if (img_w == 0 || img_h == 0) close_record();
          else dec_phase = DecImage;
        end
      end
      DecImage: begin
        if (gray_img) begin
          emit_run(b, 1, 1'b0);
        end else if (b == 0) begin
          black_next = ~black_next;  // empty run still swaps colour
        end else begin
          run     = b;
          clipped = 1'b0;
          if (run > img_w - cur_col) begin
            run     = img_w - cur_col;
            clipped = 1'b1;
          end
          colour     = black_next;
          black_next = ~black_next;
          emit_run({7'd0, colour}, run, clipped);
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                runs_seen, field, got, want));
  endtask

  task automatic check_run(input out_beat_t got);
    out_beat_t want;
    if (expected_runs.size() == 0) begin
      report_mismatch($sformatf("unexpected result %p", got));
      return;
    end
    want = expected_runs.pop_front();
    compare_field("pixel_value", got.pixel_value, want.pixel_value);
    compare_field("run_length", got.run_length, want.run_length);
    compare_field("start_column", got.start_column, want.start_column);
    compare_field("row_number", got.row_number, want.row_number);
    compare_field("sample_label", got.sample_label, want.sample_label);
    compare_field("sample_number", got.sample_number, want.sample_number);
    compare_field("row_end", got.row_end, want.row_end);
    compare_field("sample_end", got.sample_end, want.sample_end);
    compare_field("format_error", got.format_error, want.format_error);
    runs_seen++;
  endtask

  // Predict on every accepted input beat, check every accepted result beat.
  // Results are registered after their bytes, so predicting first is safe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.payload);
        beats_taken++;
      end
      if (out_ch.valid && out_ch.ready) check_run(out_ch.payload);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps (gap may be zero)
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid   <= 1'b0;
      in_ch.payload <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left != 0 || file_bytes.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        in_ch.valid   <= 1'b1;
        in_ch.payload <= file_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left <= int'($urandom_range(1, 48));
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: rotates a ready pattern, reloaded now and then; all-ones patterns
  // give stretches with no stall at all
  // ---------------------------------------------------------------------------
  logic [31:0] ready_pat;
  int          pat_hold;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      ready_pat    <= '1;
      pat_hold     <= 0;
    end else if (pat_hold == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pat <= '1;
        1:       ready_pat <= $urandom() | 32'h1;
        2:       ready_pat <= ($urandom() & $urandom()) | 32'h1;
        default: ready_pat <= $urandom() | $urandom();
      endcase
      pat_hold     <= int'($urandom_range(16, 400));
      out_ch.ready <= 1'b1;
    end else begin
      ready_pat    <= {ready_pat[0], ready_pat[31:1]};
      pat_hold     <= pat_hold - 1;
      out_ch.ready <= ready_pat[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b, input logic fs);
    in_beat_t beat;
    beat.data_byte  = b;
    beat.file_start = fs;
    file_bytes.push_back(beat);
  endtask

  // Full header, random filler except the fields the parser captures
  task automatic put_header(input logic fs, input logic [7:0] dw, input logic [7:0] dh,
                            input logic [31:0] total, input logic [7:0] mode);
    for (int i = 0; i < HdrBytes; i++) begin
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (i == OfsWidth) b = dw;
      else if (i == OfsHeight) b = dh;
      else if (i >= OfsTotal && i < OfsTotal + 4) b = total[8 * (i - OfsTotal) +: 8];
      else if (i == OfsMode) b = mode;
      put_byte(b, (i == 0) ? fs : 1'b0);
    end
  endtask

  // Start byte, label, optional size and the two skipped length bytes
  task automatic put_record_head(input logic [7:0] start_b, input logic [7:0] label,
                                 input bit sized, input logic [7:0] w, input logic [7:0] h);
    put_byte(start_b, 1'b0);
    put_byte(label, 1'b0);
    if (sized) begin
      put_byte(w, 1'b0);
      put_byte(h, 1'b0);
    end
    put_byte(8'($urandom_range(0, 255)), 1'b0);
    put_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Binary image body: rows of runs summing to the width, with the odd empty
  // run and the odd overrun
  task automatic put_image(input logic [7:0] w, input logic [7:0] h);
    if (w == 0 || h == 0) return;
    for (int r = 0; r < int'(h); r++) begin
      int left;
      int run;
      left = int'(w);
      while (left > 0) begin
        if ($urandom_range(0, 9) == 0) begin
          put_byte(8'd0, 1'b0);
        end else if ($urandom_range(0, 19) == 0 && left < 255) begin
          put_byte(8'($urandom_range(left + 1, 255)), 1'b0);
          left = 0;
        end else begin
          run = int'($urandom_range(1, left));
          put_byte(8'(run), 1'b0);
          left -= run;
        end
      end
    end
  endtask

  // Sized binary record with random content, now and then empty or badly started
  task automatic put_random_record();
    logic [7:0] w;
    logic [7:0] h;
    logic [7:0] start_b;
    w = 8'($urandom_range(1, 16));
    h = 8'($urandom_range(1, 8));
    if ($urandom_range(0, 7) == 0) w = 8'd255;
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) w = 8'd0;
      else h = 8'd0;
    end
    start_b = StartMarker;
    if ($urandom_range(0, 9) == 0) start_b = 8'($urandom_range(0, 254));
    put_record_head(start_b, 8'($urandom_range(0, 255)), 1'b1, w, h);
    put_image(w, h);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] total;

    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    rst_ni         = 1'b0;
    beats_taken    = 0;
    runs_seen      = 0;
    mismatch_count = 0;
    clear_decoder();

    // File parsed from reset without a file_start: binary mode, only one
    // default set, so every record gives its own size
    total = 32'(4 + NumRandRecords + 1);
    put_header(1'b0, 8'd0, 8'd7, total, 8'h00);
    put_record_head(StartMarker, 8'h00, 1'b1, 8'd4, 8'd2);
    put_byte(8'd0, 1'b0);    // empty white run, row starts black
    put_byte(8'd4, 1'b0);
    put_byte(8'd1, 1'b0);    // next row restarts white
    put_byte(8'd2, 1'b0);
    put_byte(8'd1, 1'b0);
    put_record_head(8'h00, 8'hFF, 1'b1, 8'd3, 8'd1);  // wrong start byte
    put_byte(8'd5, 1'b0);    // overruns the row, clipped to 3
    put_record_head(StartMarker, 8'h5A, 1'b1, 8'd0, 8'd3);  // zero width
    put_record_head(StartMarker, 8'hA5, 1'b1, 8'd255, 8'd2);
    put_byte(8'd255, 1'b0);
    put_byte(8'd254, 1'b0);
    put_byte(8'd1, 1'b0);    // run at the last column

    // Random records of the same file
    repeat (NumRandRecords) put_random_record();

    put_record_head(StartMarker, 8'h07, 1'b1, 8'd2, 8'd0);  // zero height, last record
    put_byte(8'h3C, 1'b0);   // past the last record
    put_byte(8'hFF, 1'b0);

    // New file abandoned part way through its header
    put_byte(8'($urandom_range(0, 255)), 1'b1);
    repeat (40) put_byte(8'($urandom_range(0, 255)), 1'b0);

    beats_total = file_bytes.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_taken != beats_total) @(posedge clk_i);
    while (expected_runs.size() != 0) @(posedge clk_i);
    // room for any stray result still in the pipeline
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
